>>> hw/rtl/rgbhsv_pkg.sv
// ----------------------------------------------------------------------------
// rgbhsv_pkg
// Shared widths, constants and payload types of the RGB to HSV converter.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

  // Channel width and divider widths
  localparam int PIX_W = 8;
  localparam int NUM_W = 16;

  // Hue sector arithmetic
  localparam logic [PIX_W-1:0] HUE_STEP     = 8'd43;
  localparam logic [PIX_W-1:0] OFFSET_RED   = 8'd0;
  localparam logic [PIX_W-1:0] OFFSET_GREEN = 8'd85;
  localparam logic [PIX_W-1:0] OFFSET_BLUE  = 8'd171;
  localparam logic [PIX_W-1:0] FULL_SCALE   = 8'd255;

  // Input transaction
  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } pixel_t;

  // Output transaction
  typedef struct packed {
    logic [PIX_W-1:0] hue;
    logic [PIX_W-1:0] saturation;
    logic [PIX_W-1:0] brightness;
  } hsv_t;

  // Per-item data that rides alongside the divider stages
  typedef struct packed {
    logic [PIX_W-1:0] hi;
    logic [PIX_W-1:0] offset;
    logic             neg;
    logic             span_zero;
  } side_t;

endpackage

>>> hw/rtl/rgb_to_hsv_integer_core.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_integer_core
// 8-bit RGB to 8-bit HSV converter, fully pipelined.
//
//   channel | signals                       | payload
//   --------+-------------------------------+-----------------------------
//   pixel   | pixel_valid / pixel_ready     | pixel_t {red, green, blue}
//   hsv     | hsv_valid / hsv_ready         | hsv_t {hue, saturation, brightness}
//
// Throughput is one transaction per clock while the hsv side does not stall.
// The stages are the two 8-stage restoring dividers, side by side (one
// quotient bit per stage), plus one min/max, one scaling and one output stage.
// Reset clears only the per-stage valid bits.
// Each stage loads when it is empty or its successor loads, so bubbles are
// squeezed out and input is taken while a result waits, until all stages fill.
// ----------------------------------------------------------------------------
module rgb_to_hsv_integer_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               pixel_valid,
  output logic               pixel_ready,
  input  rgbhsv_pkg::pixel_t pixel,
  output logic               hsv_valid,
  input  logic               hsv_ready,
  output rgbhsv_pkg::hsv_t   hsv
);
  import rgbhsv_pkg::*;

  localparam int DIV_FIRST  = 2;
  localparam int OUT_STAGE  = DIV_FIRST + PIX_W;
  localparam int NUM_STAGES = OUT_STAGE + 1;

  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] load;

  // Per-stage load enables, chained back from the output
  always_comb begin
    load[NUM_STAGES-1] = !vld[NUM_STAGES-1] || hsv_ready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      load[i] = !vld[i] || load[i+1];
    end
  end

  assign pixel_ready = load[0];
  assign hsv_valid   = vld[NUM_STAGES-1];

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (load[0]) begin
        vld[0] <= pixel_valid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (load[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // Stage A: max, min, sector select, signed difference
  logic [PIX_W-1:0] hi;
  logic [PIX_W-1:0] lo;
  logic [PIX_W-1:0] op_a;
  logic [PIX_W-1:0] op_c;
  side_t            side_a_next;
  logic [PIX_W-1:0] mag_a_next;

  always_comb begin
    hi = pixel.red;
    if (pixel.green > hi) begin
      hi = pixel.green;
    end
    if (pixel.blue > hi) begin
      hi = pixel.blue;
    end
    lo = pixel.red;
    if (pixel.green < lo) begin
      lo = pixel.green;
    end
    if (pixel.blue < lo) begin
      lo = pixel.blue;
    end

    // Red wins ties, then green
    if (hi == pixel.red) begin
      side_a_next.offset = OFFSET_RED;
      op_a               = pixel.green;
      op_c               = pixel.blue;
    end else if (hi == pixel.green) begin
      side_a_next.offset = OFFSET_GREEN;
      op_a               = pixel.blue;
      op_c               = pixel.red;
    end else begin
      side_a_next.offset = OFFSET_BLUE;
      op_a               = pixel.red;
      op_c               = pixel.green;
    end

    side_a_next.hi        = hi;
    side_a_next.neg       = (op_a < op_c);
    side_a_next.span_zero = (hi == lo);
    mag_a_next            = side_a_next.neg ? (op_c - op_a) : (op_a - op_c);
  end

  side_t            side_a;
  logic [PIX_W-1:0] span_a;
  logic [PIX_W-1:0] mag_a;

  always_ff @(posedge clk) begin
    if (load[0]) begin
      side_a <= side_a_next;
      span_a <= hi - lo;
      mag_a  <= mag_a_next;
    end
  end

  // Stage B: scale the dividends by constants
  side_t            side_b;
  logic [PIX_W-1:0] span_b;
  logic [NUM_W-1:0] num_sat_b;
  logic [NUM_W-1:0] num_hue_b;

  always_ff @(posedge clk) begin
    if (load[1]) begin
      side_b    <= side_a;
      span_b    <= span_a;
      num_sat_b <= NUM_W'(FULL_SCALE) * NUM_W'(span_a);
      num_hue_b <= NUM_W'(HUE_STEP) * NUM_W'(mag_a);
    end
  end

  // Divider stages: side data follows alongside
  side_t side_d [PIX_W];

  always_ff @(posedge clk) begin
    if (load[DIV_FIRST]) begin
      side_d[0] <= side_b;
    end
    for (int j = 1; j < PIX_W; j++) begin
      if (load[DIV_FIRST+j]) begin
        side_d[j] <= side_d[j-1];
      end
    end
  end

  logic [PIX_W-1:0] sat_q;
  logic [PIX_W-1:0] hue_q;

  rgbhsv_div_pipe #(
    .NUM_W (NUM_W),
    .DEN_W (PIX_W),
    .QUO_W (PIX_W)
  ) u_div_sat (
    .clk  (clk),
    .load (load[DIV_FIRST +: PIX_W]),
    .num  (num_sat_b),
    .den  (side_b.hi),
    .quo  (sat_q)
  );

  rgbhsv_div_pipe #(
    .NUM_W (NUM_W),
    .DEN_W (PIX_W),
    .QUO_W (PIX_W)
  ) u_div_hue (
    .clk  (clk),
    .load (load[DIV_FIRST +: PIX_W]),
    .num  (num_hue_b),
    .den  (span_b),
    .quo  (hue_q)
  );

  // Output stage: sector offset plus signed hue term, grey and black to zero
  side_t side_last;
  hsv_t  hsv_next;

  assign side_last = side_d[PIX_W-1];

  always_comb begin
    hsv_next.brightness = side_last.hi;
    if (side_last.span_zero) begin
      hsv_next.saturation = '0;
      hsv_next.hue        = '0;
    end else begin
      hsv_next.saturation = sat_q;
      hsv_next.hue        = side_last.neg ? (side_last.offset - hue_q)
                                          : (side_last.offset + hue_q);
    end
  end

  always_ff @(posedge clk) begin
    if (load[OUT_STAGE]) begin
      hsv <= hsv_next;
    end
  end

  // Checks
  a_full_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !pixel_ready |-> ((&vld) && !hsv_ready))
    else $error("input blocked while pipeline has a free stage");

  a_bubble_enters: assert property (@(posedge clk) disable iff (rst)
    (pixel_ready && !pixel_valid) |=> !vld[0])
    else $error("first stage marked valid without a transaction");

  a_grey_hue: assert property (@(posedge clk) disable iff (rst)
    (hsv_valid && hsv.saturation == '0) |-> (hsv.hue == '0))
    else $error("nonzero hue with zero saturation");

  a_black_sat: assert property (@(posedge clk) disable iff (rst)
    (hsv_valid && hsv.brightness == '0) |-> (hsv.saturation == '0))
    else $error("nonzero saturation on a black pixel");

endmodule

>>> hw/rtl/rgbhsv_div_pipe.sv
// ----------------------------------------------------------------------------
// rgbhsv_div_pipe
// Pipelined restoring divider, one quotient bit per register stage, MSB
// first. The quotient must fit in QUO_W bits (num < den << QUO_W).
// ----------------------------------------------------------------------------
module rgbhsv_div_pipe #(
  parameter int NUM_W = rgbhsv_pkg::NUM_W,
  parameter int DEN_W = rgbhsv_pkg::PIX_W,
  parameter int QUO_W = rgbhsv_pkg::PIX_W
) (
  input  logic             clk,
  input  logic [QUO_W-1:0] load,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QUO_W-1:0] quo
);
  import rgbhsv_pkg::*;

  localparam int REM_W = DEN_W + QUO_W;

  logic [REM_W-1:0] rem [QUO_W];
  logic [DEN_W-1:0] dvs [QUO_W];
  logic [QUO_W-1:0] qt  [QUO_W];

  for (genvar s = 0; s < QUO_W; s++) begin : g_step
    localparam int SH = QUO_W - 1 - s;

    logic [REM_W-1:0] rem_in;
    logic [REM_W-1:0] trial;
    logic [DEN_W-1:0] dvs_in;
    logic [QUO_W-1:0] qt_in;
    logic             bit_set;

    // Stage inputs: first stage takes the operands
    if (s == 0) begin : g_first
      assign rem_in = REM_W'(num);
      assign dvs_in = den;
      assign qt_in  = '0;
    end else begin : g_next
      assign rem_in = rem[s-1];
      assign dvs_in = dvs[s-1];
      assign qt_in  = qt[s-1];
    end

    // Trial subtract of the shifted divisor
    assign trial   = REM_W'(dvs_in) << SH;
    assign bit_set = (rem_in >= trial);

    always_ff @(posedge clk) begin
      if (load[s]) begin
        qt[s] <= {qt_in[QUO_W-2:0], bit_set};
        if (s < QUO_W - 1) begin
          rem[s] <= bit_set ? (rem_in - trial) : rem_in;
          dvs[s] <= dvs_in;
        end
      end
    end
  end

  assign quo = qt[QUO_W-1];

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for rgb_to_hsv_integer_core. Pixels go in through a
// bursty valid/ready sender while the HSV side stalls on its own pattern.
// Every accepted pixel is converted by a bench-side model and queued; every
// accepted HSV transaction is compared field by field with the oldest entry.
// ----------------------------------------------------------------------------
module tb;
  import rgbhsv_pkg::*;

  localparam int RANDOM_PIXELS  = 2000;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 24;

  // Expected-HSV store and pixel-to-HSV model
  class hsv_scoreboard;
    hsv_t expected_hsv_q[$];
    int   errors = 0;

    // Integer HSV conversion: max is value, sector chosen red, green, blue
    function hsv_t convert(pixel_t p);
      hsv_t o;
      int r, g, b, hi, lo, span, offset, diff, sat, hue_sum;
      r = p.red;
      g = p.green;
      b = p.blue;
      hi = r;
      lo = r;
      if (g > hi) hi = g;
      if (b > hi) hi = b;
      if (g < lo) lo = g;
      if (b < lo) lo = b;
      span = hi - lo;
      sat = 0;
      if (hi != 0) sat = (255 * span) / hi;
      hue_sum = 0;
      if (hi != 0 && sat != 0 && span != 0) begin
        if (hi == r) begin
          offset = 0;
          diff = g - b;
        end else if (hi == g) begin
          offset = 85;
          diff = b - r;
        end else begin
          offset = 171;
          diff = r - g;
        end
        // int division truncates toward zero; sum wraps at 8 bits
        hue_sum = offset + (43 * diff) / span;
      end
      o.hue        = hue_sum[PIX_W-1:0];
      o.saturation = sat[PIX_W-1:0];
      o.brightness = hi[PIX_W-1:0];
      return o;
    endfunction

    function void note_pixel(pixel_t p);
      expected_hsv_q.push_back(convert(p));
    endfunction

    function void check_hsv(hsv_t got);
      hsv_t want;
      if (expected_hsv_q.size() == 0) begin
        $error("unexpected hsv transaction: hue %0d sat %0d val %0d",
               got.hue, got.saturation, got.brightness);
        errors++;
        return;
      end
      want = expected_hsv_q.pop_front();
      if (got.hue !== want.hue) begin
        $error("hue mismatch: expected %0d, actual %0d", want.hue, got.hue);
        errors++;
      end
      if (got.saturation !== want.saturation) begin
        $error("saturation mismatch: expected %0d, actual %0d",
               want.saturation, got.saturation);
        errors++;
      end
      if (got.brightness !== want.brightness) begin
        $error("brightness mismatch: expected %0d, actual %0d",
               want.brightness, got.brightness);
        errors++;
      end
    endfunction

    function int pending();
      return expected_hsv_q.size();
    endfunction
  endclass

  logic   clk         = 1'b0;
  logic   rst         = 1'b1;
  logic   pixel_valid = 1'b0;
  logic   pixel_ready;
  pixel_t pixel       = '0;
  logic   hsv_valid;
  logic   hsv_ready   = 1'b0;
  hsv_t   hsv;

  hsv_scoreboard sb = new();

  rgb_to_hsv_integer_core dut (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel       (pixel),
    .hsv_valid   (hsv_valid),
    .hsv_ready   (hsv_ready),
    .hsv         (hsv)
  );

  always #2 clk = ~clk;

  // Monitor: log accepted pixels, check accepted results
  always @(posedge clk) begin
    if (!rst) begin
      if (pixel_valid && pixel_ready) sb.note_pixel(pixel);
      if (hsv_valid && hsv_ready) sb.check_hsv(hsv);
    end
  end

  // Watchdog on cycles with no transaction on either side
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if ((pixel_valid && pixel_ready) || (hsv_valid && hsv_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Receiver back-pressure: switches between a few stall styles
  int rx_mode  = 0;
  int rx_left  = 0;
  int rx_phase = 0;
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_left <= $urandom_range(20, 200);
    end else begin
      rx_left <= rx_left - 1;
    end
    rx_phase <= rx_phase + 1;
    case (rx_mode)
      0: hsv_ready <= 1'b1;
      1: hsv_ready <= 1'($urandom_range(0, 1));
      2: hsv_ready <= (rx_phase % 5) < 2;
      default: hsv_ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Present one pixel and hold it until taken; valid stays high afterwards
  task automatic send_pixel(input pixel_t p);
    pixel       <= p;
    pixel_valid <= 1'b1;
    @(posedge clk);
    while (!pixel_ready) @(posedge clk);
  endtask

  task automatic idle_cycles(input int n);
    pixel_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Hold off the sender until every queued result has come back
  task automatic wait_drained();
    pixel_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic pixel_t mk_pixel(int r, int g, int b);
    pixel_t p;
    p.red   = r[PIX_W-1:0];
    p.green = g[PIX_W-1:0];
    p.blue  = b[PIX_W-1:0];
    return p;
  endfunction

  // Random pixel, biased toward greys, ties and channel extremes
  function automatic pixel_t rand_pixel();
    int m, o, v;
    m = $urandom_range(0, 255);
    o = $urandom_range(0, m);
    v = $urandom_range(0, 255);
    case ($urandom_range(0, 9))
      0: return mk_pixel(v, v, v);
      1: begin
        case ($urandom_range(0, 2))
          0: return mk_pixel(m, m, o);
          1: return mk_pixel(m, o, m);
          default: return mk_pixel(o, m, m);
        endcase
      end
      2: return mk_pixel($urandom_range(0, 1) ? 255 - $urandom_range(0, 1)
                                              : $urandom_range(0, 1),
                         $urandom_range(0, 1) ? 255 - $urandom_range(0, 1)
                                              : $urandom_range(0, 1),
                         $urandom_range(0, 1) ? 255 - $urandom_range(0, 1)
                                              : $urandom_range(0, 1));
      3: return mk_pixel($urandom_range(0, 3), $urandom_range(0, 3),
                         $urandom_range(0, 3));
      default: return mk_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                               $urandom_range(0, 255));
    endcase
  endfunction

  // Stimulus
  initial begin
    pixel_t directed_q[$];
    int     sent;
    int     burst;
    int     gap;
    bit     paused;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // black, white, grey and primaries
    directed_q.push_back(mk_pixel(0, 0, 0));
    directed_q.push_back(mk_pixel(255, 255, 255));
    directed_q.push_back(mk_pixel(128, 128, 128));
    directed_q.push_back(mk_pixel(255, 0, 0));
    directed_q.push_back(mk_pixel(0, 255, 0));
    directed_q.push_back(mk_pixel(0, 0, 255));
    // ties for the max: red over green and blue, green over blue
    directed_q.push_back(mk_pixel(255, 255, 0));
    directed_q.push_back(mk_pixel(255, 0, 255));
    directed_q.push_back(mk_pixel(0, 255, 255));
    // negative hue term in each sector
    directed_q.push_back(mk_pixel(255, 0, 10));
    directed_q.push_back(mk_pixel(10, 255, 0));
    directed_q.push_back(mk_pixel(0, 10, 255));
    // smallest nonzero values and near-full ranges
    directed_q.push_back(mk_pixel(1, 0, 0));
    directed_q.push_back(mk_pixel(0, 0, 1));
    directed_q.push_back(mk_pixel(1, 1, 0));
    directed_q.push_back(mk_pixel(255, 254, 255));
    directed_q.push_back(mk_pixel(254, 255, 254));
    directed_q.push_back(mk_pixel(255, 128, 0));
    directed_q.push_back(mk_pixel(128, 255, 0));
    directed_q.push_back(mk_pixel(170, 85, 255));
    foreach (directed_q[i]) send_pixel(directed_q[i]);

    wait_drained();

    // Random bursts with random gaps, plus a mid-run drain
    sent = 0;
    paused = 1'b0;
    while (sent < RANDOM_PIXELS) begin
      burst = $urandom_range(1, 40);
      if ($urandom_range(0, 5) == 0) burst = 200;
      for (int k = 0; k < burst && sent < RANDOM_PIXELS; k++) begin
        send_pixel(rand_pixel());
        sent++;
      end
      if (!paused && sent >= RANDOM_PIXELS / 2) begin
        paused = 1'b1;
        wait_drained();
      end else begin
        gap = $urandom_range(0, 6);
        if (gap > 0) idle_cycles(gap);
      end
    end

    // Drain, then let the pipeline settle
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d expected hsv transactions never arrived", sb.pending());
      sb.errors++;
    end

    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/rgbhsv_pkg.sv
hw/rtl/rgbhsv_div_pipe.sv
hw/rtl/rgb_to_hsv_integer_core.sv
verif/tb.sv
